>>> sv/acs_pkg.sv
// shared types, codes, command text and constants of the axis command sequencer
package acs_pkg;

  // sizing
  localparam int AxisCount  = 2;
  localparam int PosChars   = 7;
  localparam int QueueDepth = 2;
  localparam int AxisIdxW   = (AxisCount > 1) ? $clog2(AxisCount) : 1;
  localparam int QueueIdxW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);
  localparam int StepW      = 4;
  localparam int PosW       = 25;
  localparam int MagDigits  = 8;
  localparam int DigIdxW    = 3;
  localparam int DigCntW    = 4;
  localparam int TextIdW    = 3;
  localparam int TextIdxW   = 4;
  localparam int TextChars  = 11;

  // position saturation bounds, a minus sign takes one character
  localparam longint PosHi = (longint'(10) ** PosChars) - 1;
  localparam longint PosLo = -((longint'(10) ** (PosChars - 1)) - 1);

  // divide by ten through the reciprocal, exact for 32-bit values
  localparam logic [31:0] DivTenRecip = 32'hCCCCCCCD;
  localparam int          DivTenShift = 35;

  // command codes
  localparam logic [1:0] CmdHome  = 2'd0;
  localparam logic [1:0] CmdMove  = 2'd1;
  localparam logic [1:0] CmdReset = 2'd2;

  // reply codes
  localparam logic [2:0] RespNone   = 3'd0;
  localparam logic [2:0] RespAck    = 3'd1;
  localparam logic [2:0] RespMsg    = 3'd2;
  localparam logic [2:0] RespEMsg   = 3'd3;
  localparam logic [2:0] RespNoData = 3'd4;
  localparam logic [2:0] RespError  = 3'd5;

  // sequence steps
  localparam logic [StepW-1:0] StepZero     = 4'd0;
  localparam logic [StepW-1:0] HomeLastStep = 4'd13;
  localparam logic [StepW-1:0] MoveLastStep = 4'd5;
  localparam logic [StepW-1:0] MovePosStep  = 4'd2;

  // command text ids
  localparam logic [TextIdW-1:0] TextMoveN = 3'd4;
  localparam logic [TextIdW-1:0] TextMoveF = 3'd0;
  localparam logic [TextIdW-1:0] TextMoveA = 3'd7;

  // characters
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChG     = 8'h47;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNone  = 8'h00;

  // command text, right aligned, home sequence first then the move prefix
  localparam logic [8*TextChars-1:0] TextStr [8] = '{
    "f1xG", "E1xG", "C1x2r2t0.2G", "V1x100G", "n1xG", "H1xG", "f1xG", "A1x"
  };
  localparam logic [TextIdxW-1:0] TextLen [8] = '{
    4'd4, 4'd4, 4'd11, 4'd7, 4'd4, 4'd4, 4'd4, 4'd3
  };

  typedef enum logic [1:0] {
    JOB_IDLE,
    JOB_TEXT,
    JOB_MOVE
  } job_kind_e;

  // one classified request handed from front to back
  typedef struct packed {
    job_kind_e          kind;
    logic               axis;
    logic               fin;
    logic [TextIdW-1:0] text_id;
    logic               neg;
    logic [PosW-1:0]    mag;
  } job_t;

  // character idx of command text id
  function automatic logic [7:0] text_char(logic [TextIdW-1:0] id, logic [TextIdxW-1:0] idx);
    logic [8*TextChars-1:0] s;
    logic [TextIdxW-1:0]    pos;
    s   = TextStr[id];
    pos = TextLen[id] - 4'd1 - idx;
    return s[{pos, 3'b000} +: 8];
  endfunction

endpackage

>>> sv/acs_front.sv
// front end: accepts requests, walks the per-axis step counters, classifies the work
module acs_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            command_i,
  input  logic                  axis_i,
  input  logic signed [24:0]    target_position_i,
  input  logic                  tx_space_i,
  input  logic [2:0]            response_code_i,
  input  logic                  full_i,
  output logic                  push_o,
  output acs_pkg::job_t         job_o
);

  logic [acs_pkg::StepW-1:0]    step_q [acs_pkg::AxisCount];
  logic [acs_pkg::StepW-1:0]    step_d;
  logic [acs_pkg::StepW-1:0]    step_cur;
  logic [acs_pkg::StepW-1:0]    last_step;
  logic [acs_pkg::AxisIdxW-1:0] ax_idx;
  logic                         ax_ok;
  logic                         step_we;
  logic signed [63:0]           pos_ext;
  logic signed [63:0]           pos_sat;
  logic [63:0]                  mag_ext;
  logic                         neg;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign ax_ok      = (int'(axis_i) < acs_pkg::AxisCount);
  assign ax_idx     = acs_pkg::AxisIdxW'(axis_i);
  assign step_cur   = step_q[ax_idx];

  // clamp the target to what fits in the position characters
  always_comb begin
    pos_ext = 64'(target_position_i);
    if (pos_ext > acs_pkg::PosHi) begin
      pos_sat = acs_pkg::PosHi;
    end else if (pos_ext < acs_pkg::PosLo) begin
      pos_sat = acs_pkg::PosLo;
    end else begin
      pos_sat = pos_ext;
    end
    neg     = (pos_sat < 0);
    mag_ext = neg ? 64'(-pos_sat) : 64'(pos_sat);
  end

  // step decision and job classification
  always_comb begin
    job_o.kind    = acs_pkg::JOB_IDLE;
    job_o.axis    = axis_i;
    job_o.fin     = 1'b0;
    job_o.text_id = acs_pkg::TextMoveF;
    job_o.neg     = neg;
    job_o.mag     = mag_ext[acs_pkg::PosW-1:0];
    step_d        = step_cur;
    step_we       = 1'b0;
    last_step     = (command_i == acs_pkg::CmdHome) ? acs_pkg::HomeLastStep
                                                    : acs_pkg::MoveLastStep;
    if (ax_ok) begin
      if (command_i == acs_pkg::CmdReset) begin
        step_d  = acs_pkg::StepZero;
        step_we = 1'b1;
      end else if ((command_i == acs_pkg::CmdHome || command_i == acs_pkg::CmdMove)
                   && step_cur <= last_step) begin
        if (!step_cur[0]) begin
          // even step: send the next command when there is room
          if (tx_space_i) begin
            step_d  = step_cur + 4'd1;
            step_we = 1'b1;
            if (command_i == acs_pkg::CmdHome) begin
              job_o.kind    = acs_pkg::JOB_TEXT;
              job_o.text_id = step_cur[acs_pkg::StepW-1:1];
            end else if (step_cur == acs_pkg::StepZero) begin
              job_o.kind    = acs_pkg::JOB_TEXT;
              job_o.text_id = acs_pkg::TextMoveN;
            end else if (step_cur == acs_pkg::MovePosStep) begin
              job_o.kind    = acs_pkg::JOB_MOVE;
              job_o.text_id = acs_pkg::TextMoveA;
            end else begin
              job_o.kind    = acs_pkg::JOB_TEXT;
              job_o.text_id = acs_pkg::TextMoveF;
            end
          end
        end else begin
          // odd step: wait for the reply
          if (response_code_i == acs_pkg::RespAck) begin
            step_we = 1'b1;
            if (step_cur == last_step) begin
              step_d    = acs_pkg::StepZero;
              job_o.fin = 1'b1;
            end else begin
              step_d = step_cur + 4'd1;
            end
          end else if (response_code_i inside {acs_pkg::RespEMsg, acs_pkg::RespNoData,
                                               acs_pkg::RespError}) begin
            step_d  = acs_pkg::StepZero;
            step_we = 1'b1;
          end
        end
      end
    end
  end

  // step counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < acs_pkg::AxisCount; i++) begin
        step_q[i] <= acs_pkg::StepZero;
      end
    end else if (push_o && step_we) begin
      step_q[ax_idx] <= step_d;
    end
  end

  // a step never passes the last home step
  for (genvar g = 0; g < acs_pkg::AxisCount; g++) begin : g_step_chk
    a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      step_q[g] <= acs_pkg::HomeLastStep)
      else $error("step counter beyond the home sequence");
  end

endmodule

>>> sv/acs_queue.sv
// short request queue between the front and the back end
module acs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  acs_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output acs_pkg::job_t head_o
);

  acs_pkg::job_t                 mem_q [acs_pkg::QueueDepth];
  logic [acs_pkg::QueueIdxW-1:0] wr_ptr_q;
  logic [acs_pkg::QueueIdxW-1:0] rd_ptr_q;
  logic [acs_pkg::QueueCntW-1:0] count_q;

  assign full_o  = (count_q == acs_pkg::QueueCntW'(acs_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == acs_pkg::QueueIdxW'(acs_pkg::QueueDepth - 1))
                    ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == acs_pkg::QueueIdxW'(acs_pkg::QueueDepth - 1))
                    ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue read while empty");

endmodule

>>> sv/acs_back.sv
// back end: converts position, sends command chars one a cycle unless stalled
module acs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  acs_pkg::job_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          byte_valid_o,
  output logic [7:0]    tx_byte_o,
  output logic          tx_axis_o,
  output logic          finished_o,
  output logic          last_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_TEXT = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_DIG  = 3'd4;
  localparam logic [2:0] ST_GCH  = 3'd5;
  localparam logic [2:0] ST_CR   = 3'd6;
  localparam logic [2:0] ST_LF   = 3'd7;

  logic [2:0]                     state_q, state_d;
  acs_pkg::job_t                  job_q, job_d;
  logic [acs_pkg::TextIdxW-1:0]   idx_q, idx_d;
  logic [acs_pkg::PosW-1:0]       mag_q, mag_d;
  logic [acs_pkg::DigCntW-1:0]    ndig_q, ndig_d;
  logic [acs_pkg::DigIdxW-1:0]    dig_idx_q, dig_idx_d;
  logic [3:0]                     digits_q [acs_pkg::MagDigits];
  logic                           dig_we;

  logic                           out_valid_q;
  logic                           byte_valid_q;
  logic [7:0]                     tx_byte_q;
  logic                           tx_axis_q;
  logic                           finished_q;
  logic                           last_q;

  logic                           out_free;
  logic                           emit;
  logic                           emit_bv;
  logic [7:0]                     emit_ch;
  logic                           emit_axis;
  logic                           emit_fin;
  logic                           emit_last;

  logic [acs_pkg::PosW+31:0]      prod;
  logic [acs_pkg::PosW-1:0]       quot;
  logic [acs_pkg::PosW-1:0]       quot10;
  logic [3:0]                     digit;

  assign out_free = !out_valid_q || !out_stall_i;

  // one decimal digit per cycle, least significant first
  always_comb begin
    prod   = mag_q * acs_pkg::DivTenRecip;
    quot   = acs_pkg::PosW'(prod >> acs_pkg::DivTenShift);
    quot10 = (quot << 3) + (quot << 1);
    digit  = 4'(mag_q - quot10);
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    idx_d     = idx_q;
    mag_d     = mag_q;
    ndig_d    = ndig_q;
    dig_idx_d = dig_idx_q;
    dig_we    = 1'b0;
    pop_o     = 1'b0;
    emit      = 1'b0;
    emit_bv   = 1'b1;
    emit_ch   = acs_pkg::ChNone;
    emit_axis = job_q.axis;
    emit_fin  = 1'b0;
    emit_last = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i && out_free) begin
          pop_o = 1'b1;
          job_d = head_i;
          idx_d = '0;
          if (head_i.kind == acs_pkg::JOB_IDLE) begin
            emit      = 1'b1;
            emit_bv   = 1'b0;
            emit_axis = head_i.axis;
            emit_fin  = head_i.fin;
            emit_last = 1'b1;
          end else if (head_i.kind == acs_pkg::JOB_MOVE) begin
            mag_d   = head_i.mag;
            ndig_d  = '0;
            state_d = ST_CONV;
          end else begin
            state_d = ST_TEXT;
          end
        end
      end
      ST_CONV: begin
        dig_we = 1'b1;
        ndig_d = ndig_q + 1'b1;
        mag_d  = quot;
        if (quot == '0) begin
          dig_idx_d = ndig_q[acs_pkg::DigIdxW-1:0];
          state_d   = ST_TEXT;
        end
      end
      ST_TEXT: begin
        if (out_free) begin
          emit    = 1'b1;
          emit_ch = acs_pkg::text_char(job_q.text_id, idx_q);
          if (idx_q == acs_pkg::TextLen[job_q.text_id] - 4'd1) begin
            if (job_q.kind == acs_pkg::JOB_MOVE) begin
              state_d = job_q.neg ? ST_SIGN : ST_DIG;
            end else begin
              state_d = ST_CR;
            end
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          emit    = 1'b1;
          emit_ch = acs_pkg::ChMinus;
          state_d = ST_DIG;
        end
      end
      ST_DIG: begin
        if (out_free) begin
          emit    = 1'b1;
          emit_ch = acs_pkg::ChZero + {4'b0000, digits_q[dig_idx_q]};
          if (dig_idx_q == '0) begin
            state_d = ST_GCH;
          end else begin
            dig_idx_d = dig_idx_q - 1'b1;
          end
        end
      end
      ST_GCH: begin
        if (out_free) begin
          emit    = 1'b1;
          emit_ch = acs_pkg::ChG;
          state_d = ST_CR;
        end
      end
      ST_CR: begin
        if (out_free) begin
          emit    = 1'b1;
          emit_ch = acs_pkg::ChCr;
          state_d = ST_LF;
        end
      end
      ST_LF: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_ch   = acs_pkg::ChLf;
          emit_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers, digit buffer and result register
  always_ff @(posedge clk_i) begin
    job_q     <= job_d;
    idx_q     <= idx_d;
    mag_q     <= mag_d;
    ndig_q    <= ndig_d;
    dig_idx_q <= dig_idx_d;
    if (dig_we) begin
      digits_q[ndig_q[acs_pkg::DigIdxW-1:0]] <= digit;
    end
    if (emit) begin
      byte_valid_q <= emit_bv;
      tx_byte_q    <= emit_ch;
      tx_axis_q    <= emit_axis;
      finished_q   <= emit_fin;
      last_q       <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign byte_valid_o = byte_valid_q;
  assign tx_byte_o    = tx_byte_q;
  assign tx_axis_o    = tx_axis_q;
  assign finished_o   = finished_q;
  assign last_o       = last_q;

  a_idle_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> last_o)
    else $error("result without a character is not the last of its request");

  a_fin_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && finished_o) |-> !byte_valid_o)
    else $error("finished reported with a command character");

  a_digit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIG) |-> ({1'b0, dig_idx_q} < ndig_q))
    else $error("digit read beyond the converted digits");

endmodule

>>> sv/axis_command_sequencer_unit.sv
// top level of the axis command sequencer: front end, request queue and back end
//
// Each input request is one update tick for one axis. The command field picks a home
// tick, a move tick or a reset of that axis' step counter. A tick on an even step
// sends the next command of the sequence when tx_space_i is set; on an odd step the
// reply code advances the step (ack) or sends it back to zero (e-message, no-data,
// error). The ack of the last command reports finished_o.
// A tick that sends a command returns one result per character, command text then
// CR LF, with last_o on the LF; any other tick returns a single result with
// byte_valid_o low and last_o high.
// With the queue and back end empty, an accepted request goes into the queue and is
// popped by the back end: an idle tick's result goes straight to the result register,
// a command's text is sent from the text state; a move first converts its digits.
// Throughput: the front end takes one request a cycle into a two-entry queue while it
// is not full; the back end takes a request only when idle and then sends all of its
// characters (6 to 13 per command); a move first converts its position into 1 to 7
// decimal digits by divide-by-ten. A tick that sends nothing is answered from idle.
// The receiver may stall at any time: the result register holds and the back end
// waits; requests keep being taken until the queue fills, then in_stall_o rises.
// Reset clears both step counters, the queue and the output valid.
module axis_command_sequencer_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         command_i,
  input  logic               axis_i,
  input  logic signed [24:0] target_position_i,
  input  logic               tx_space_i,
  input  logic [2:0]         response_code_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               byte_valid_o,
  output logic [7:0]         tx_byte_o,
  output logic               tx_axis_o,
  output logic               finished_o,
  output logic               last_o
);

  logic          push;
  logic          full;
  logic          pop;
  logic          empty;
  acs_pkg::job_t push_job;
  acs_pkg::job_t head_job;

  // request classification and step counters
  acs_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .axis_i            (axis_i),
    .target_position_i (target_position_i),
    .tx_space_i        (tx_space_i),
    .response_code_i   (response_code_i),
    .full_i            (full),
    .push_o            (push),
    .job_o             (push_job)
  );

  // decoupling queue
  acs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head_job)
  );

  // character generation
  acs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .byte_valid_o (byte_valid_o),
    .tx_byte_o    (tx_byte_o),
    .tx_axis_o    (tx_axis_o),
    .finished_o   (finished_o),
    .last_o       (last_o)
  );

endmodule

>>> verif/tb.sv
// self-checking testbench of the axis command sequencer: sequences, replies and byte stream
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // codes outside the defined sets
  localparam logic [1:0] CmdUnused   = 2'd3;
  localparam logic [2:0] RespUnusedA = 3'd6;
  localparam logic [2:0] RespUnusedB = 3'd7;

  // position extremes of the 25-bit field and around the seven-character bounds
  localparam logic signed [24:0] PosMax25 = 25'sh0FFFFFF;
  localparam logic signed [24:0] PosMin25 = -25'sh1000000;
  localparam logic signed [24:0] PosEdges [8] = '{
    PosMax25, PosMin25, 25'sd9999999, 25'sd10000000,
    -25'sd999999, -25'sd1000000, 25'sd0, -25'sd1
  };

  localparam int IdleLimit    = 2000;
  localparam int ItemsPerRun  = 60;
  localparam int TailCycles   = 20;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] tx_byte;
    logic       tx_axis;
    logic       finished;
    logic       last;
  } tx_result_t;

  // step counters per axis and the bytes each accepted tick should produce
  class tick_checker_t;
    tx_result_t                pending[$];
    logic [acs_pkg::StepW-1:0] step[acs_pkg::AxisCount];
    string                     home_text[7];
    int                        errors;

    function new();
      foreach (step[i]) step[i] = acs_pkg::StepZero;
      home_text = '{"f1xG", "E1xG", "C1x2r2t0.2G", "V1x100G", "n1xG", "H1xG", "f1xG"};
      errors = 0;
    endfunction

    // clamp to seven characters, minus sign included
    function string position_text(logic signed [acs_pkg::PosW-1:0] pos);
      longint v;
      v = pos;
      if (v > acs_pkg::PosHi) v = acs_pkg::PosHi;
      if (v < acs_pkg::PosLo) v = acs_pkg::PosLo;
      return $sformatf("%0d", v);
    endfunction

    // reply on a waiting step, returns 1 when the sequence completes
    function bit take_reply(logic ax, logic [2:0] resp,
                            logic [acs_pkg::StepW-1:0] last_step);
      if (resp == acs_pkg::RespAck) begin
        if (step[ax] == last_step) begin
          step[ax] = acs_pkg::StepZero;
          return 1'b1;
        end
        step[ax] = step[ax] + 1'b1;
      end else if (resp == acs_pkg::RespEMsg || resp == acs_pkg::RespNoData ||
                   resp == acs_pkg::RespError) begin
        step[ax] = acs_pkg::StepZero;
      end
      return 1'b0;
    endfunction

    function void note_request(logic [1:0] cmd, logic ax,
                               logic signed [acs_pkg::PosW-1:0] pos,
                               logic space, logic [2:0] resp);
      string                     text;
      logic [acs_pkg::StepW-1:0] s;
      bit                        fin;
      tx_result_t                r;
      text = "";
      fin  = 1'b0;
      s    = step[ax];
      if (cmd == acs_pkg::CmdReset) begin
        step[ax] = acs_pkg::StepZero;
      end else if (cmd == acs_pkg::CmdHome && s <= acs_pkg::HomeLastStep) begin
        if (!s[0]) begin
          if (space) begin
            text     = home_text[s >> 1];
            step[ax] = s + 1'b1;
          end
        end else begin
          fin = take_reply(ax, resp, acs_pkg::HomeLastStep);
        end
      end else if (cmd == acs_pkg::CmdMove && s <= acs_pkg::MoveLastStep) begin
        if (!s[0]) begin
          if (space) begin
            if (s == acs_pkg::StepZero) text = "n1xG";
            else if (s == acs_pkg::MovePosStep) text = {"A1x", position_text(pos), "G"};
            else text = "f1xG";
            step[ax] = s + 1'b1;
          end
        end else begin
          fin = take_reply(ax, resp, acs_pkg::MoveLastStep);
        end
      end
      // idle tick gives one empty result
      if (text.len() == 0) begin
        r = '{byte_valid: 1'b0, tx_byte: acs_pkg::ChNone, tx_axis: ax, finished: fin,
              last: 1'b1};
        pending.push_back(r);
      end else begin
        for (int i = 0; i < text.len(); i++) begin
          r = '{byte_valid: 1'b1, tx_byte: text[i], tx_axis: ax, finished: 1'b0, last: 1'b0};
          pending.push_back(r);
        end
        r = '{byte_valid: 1'b1, tx_byte: acs_pkg::ChCr, tx_axis: ax, finished: 1'b0,
              last: 1'b0};
        pending.push_back(r);
        r = '{byte_valid: 1'b1, tx_byte: acs_pkg::ChLf, tx_axis: ax, finished: 1'b0,
              last: 1'b1};
        pending.push_back(r);
      end
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_byte(tx_result_t got);
      tx_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, actual byte %0d valid %0b last %0b",
                 $time, got.tx_byte, got.byte_valid, got.last);
        return;
      end
      want = pending.pop_front();
      compare_field("byte_valid", want.byte_valid, got.byte_valid);
      compare_field("tx_byte", want.tx_byte, got.tx_byte);
      compare_field("tx_axis", want.tx_axis, got.tx_axis);
      compare_field("finished", want.finished, got.finished);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         command_i = acs_pkg::CmdHome;
  logic               axis_i = 1'b0;
  logic signed [24:0] target_position_i = '0;
  logic               tx_space_i = 1'b0;
  logic [2:0]         response_code_i = acs_pkg::RespNone;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               byte_valid_o;
  logic [7:0]         tx_byte_o;
  logic               tx_axis_o;
  logic               finished_o;
  logic               last_o;

  int            send_idle_pct = 17;
  int            recv_stall_pct = 80;
  logic [1:0]    axis_mode[acs_pkg::AxisCount];
  tick_checker_t board;

  axis_command_sequencer_unit DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .axis_i            (axis_i),
    .target_position_i (target_position_i),
    .tx_space_i        (tx_space_i),
    .response_code_i   (response_code_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .byte_valid_o      (byte_valid_o),
    .tx_byte_o         (tx_byte_o),
    .tx_axis_o         (tx_axis_o),
    .finished_o        (finished_o),
    .last_o            (last_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // record accepted requests, then check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        board.note_request(command_i, axis_i, target_position_i, tx_space_i, response_code_i);
      if (out_valid_o && !out_stall_i)
        board.check_byte('{byte_valid: byte_valid_o, tx_byte: tx_byte_o, tx_axis: tx_axis_o,
                           finished: finished_o, last: last_o});
    end
  end

  // watchdog on cycles with no handshake on either side
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // one request, with random idle cycles ahead of it
  task automatic send_tick(logic [1:0] cmd, logic ax, logic signed [24:0] pos,
                           logic space, logic [2:0] resp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    command_i         <= cmd;
    axis_i            <= ax;
    target_position_i <= pos;
    tx_space_i        <= space;
    response_code_i   <= resp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // sender holds off until every expected byte is out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [24:0] pick_position();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return PosEdges[$urandom_range(7)];
    if (r < 50) return 25'(int'($urandom_range(2000000)) - 1000000);
    return 25'($urandom);
  endfunction

  function automatic logic [2:0] pick_reply();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return acs_pkg::RespAck;
    if (r < 78) return acs_pkg::RespNone;
    if (r < 83) return acs_pkg::RespMsg;
    if (r < 87) return $urandom_range(1) ? RespUnusedA : RespUnusedB;
    if (r < 91) return acs_pkg::RespEMsg;
    if (r < 95) return acs_pkg::RespNoData;
    return acs_pkg::RespError;
  endfunction

  // mostly whole sequences per axis, some resets, unused codes and crossed commands
  task automatic random_ticks(int count);
    logic        ax;
    logic [1:0]  cmd;
    int unsigned r;
    for (int i = 0; i < count; i++) begin
      ax = 1'($urandom_range(1));
      r  = $urandom_range(99);
      if (r < 4) cmd = acs_pkg::CmdReset;
      else if (r < 7) cmd = CmdUnused;
      else if (r < 12)
        cmd = (axis_mode[ax] == acs_pkg::CmdHome) ? acs_pkg::CmdMove : acs_pkg::CmdHome;
      else cmd = axis_mode[ax];
      if ($urandom_range(9) == 0)
        axis_mode[ax] = (axis_mode[ax] == acs_pkg::CmdHome) ? acs_pkg::CmdMove
                                                            : acs_pkg::CmdHome;
      send_tick(cmd, ax, pick_position(), ($urandom_range(99) < 85), pick_reply());
      if ($urandom_range(99) < 3) wait_drained();
    end
  endtask

  initial begin
    board = new();
    axis_mode = '{acs_pkg::CmdHome, acs_pkg::CmdMove};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // move on the top axis: error restart, unused code, reset, full run with saturation
    send_tick(acs_pkg::CmdMove, 1'b1, 25'sd0, 1'b1, acs_pkg::RespNone);
    send_tick(acs_pkg::CmdMove, 1'b1, 25'sd0, 1'b1, acs_pkg::RespAck);
    send_tick(acs_pkg::CmdMove, 1'b1, PosMin25, 1'b1, acs_pkg::RespNone);
    send_tick(acs_pkg::CmdMove, 1'b1, 25'sd0, 1'b1, acs_pkg::RespError);
    send_tick(CmdUnused, 1'b1, PosMax25, 1'b1, acs_pkg::RespAck);
    send_tick(acs_pkg::CmdReset, 1'b1, 25'sd0, 1'b0, acs_pkg::RespNone);
    send_tick(acs_pkg::CmdMove, 1'b1, 25'sd0, 1'b1, acs_pkg::RespNone);
    send_tick(acs_pkg::CmdMove, 1'b1, 25'sd0, 1'b1, acs_pkg::RespAck);
    send_tick(acs_pkg::CmdMove, 1'b1, PosMax25, 1'b1, acs_pkg::RespNone);
    send_tick(acs_pkg::CmdMove, 1'b1, 25'sd0, 1'b1, acs_pkg::RespAck);
    send_tick(acs_pkg::CmdMove, 1'b1, 25'sd0, 1'b1, acs_pkg::RespNone);
    send_tick(acs_pkg::CmdMove, 1'b1, 25'sd0, 1'b1, acs_pkg::RespAck);
    // home on the bottom axis: no room, ignored replies, restarts, then a move past its range
    send_tick(acs_pkg::CmdHome, 1'b0, 25'sd0, 1'b0, acs_pkg::RespAck);
    send_tick(acs_pkg::CmdHome, 1'b0, 25'sd0, 1'b1, acs_pkg::RespNone);
    send_tick(acs_pkg::CmdHome, 1'b0, 25'sd0, 1'b1, acs_pkg::RespMsg);
    send_tick(acs_pkg::CmdHome, 1'b0, 25'sd0, 1'b1, RespUnusedB);
    send_tick(acs_pkg::CmdHome, 1'b0, 25'sd0, 1'b1, acs_pkg::RespNoData);
    send_tick(acs_pkg::CmdHome, 1'b0, 25'sd0, 1'b1, acs_pkg::RespNone);
    send_tick(acs_pkg::CmdHome, 1'b0, 25'sd0, 1'b1, acs_pkg::RespEMsg);
    send_tick(acs_pkg::CmdHome, 1'b0, 25'sd0, 1'b1, acs_pkg::RespNone);
    send_tick(acs_pkg::CmdHome, 1'b0, 25'sd0, 1'b1, acs_pkg::RespAck);
    send_tick(acs_pkg::CmdHome, 1'b0, 25'sd0, 1'b1, acs_pkg::RespNone);
    send_tick(acs_pkg::CmdHome, 1'b0, 25'sd0, 1'b1, acs_pkg::RespAck);
    send_tick(acs_pkg::CmdHome, 1'b0, 25'sd0, 1'b1, acs_pkg::RespNone);
    send_tick(acs_pkg::CmdHome, 1'b0, 25'sd0, 1'b1, acs_pkg::RespAck);
    send_tick(acs_pkg::CmdMove, 1'b0, 25'sd1234, 1'b1, acs_pkg::RespAck);

    random_ticks(ItemsPerRun);
    wait_drained();

    send_idle_pct  = 80;
    recv_stall_pct = 17;
    random_ticks(ItemsPerRun);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    random_ticks(ItemsPerRun);
    wait_drained();

    repeat (TailCycles) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
